/* src/grid_laplacian_gradient_stencil_core_assert.svh */
// Assertion macros used by the checker module of the stencil core.
`ifndef GRID_LAPLACIAN_GRADIENT_STENCIL_CORE_ASSERT_SVH
`define GRID_LAPLACIAN_GRADIENT_STENCIL_CORE_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define GLGS_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("stencil core check failed: same-cycle implication");

// The condition must hold in the cycle after the trigger.
`define GLGS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("stencil core check failed: next-cycle implication");

`endif

/* src/glgs_pkg.sv */
// Shared constants, codes and types of the stencil core.
package glgs_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int COORD_BITS     = 6;
    localparam int CFG_BITS       = 7;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MODE_BITS      = 2;
    localparam int LAP_BITS       = 19;
    localparam int GRAD_BITS      = 17;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EDGE_MODE   = 2'd2;

    localparam logic [MODE_BITS-1:0] EDGE_PERIODIC = 2'd0;
    localparam logic [MODE_BITS-1:0] EDGE_REFLECT  = 2'd1;
    localparam logic [MODE_BITS-1:0] EDGE_ZERO     = 2'd2;
    localparam logic [MODE_BITS-1:0] EDGE_CLAMP    = 2'd3;

    localparam logic [CFG_BITS-1:0]  RESET_GRID_WIDTH  = 7'd64;
    localparam logic [CFG_BITS-1:0]  RESET_GRID_HEIGHT = 7'd64;
    localparam logic [MODE_BITS-1:0] RESET_EDGE_MODE   = EDGE_ZERO;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam int TAP_COUNT = 5;
    localparam int TAP_C     = 0;
    localparam int TAP_N     = 1;
    localparam int TAP_S     = 2;
    localparam int TAP_E     = 3;
    localparam int TAP_W     = 4;

    typedef struct packed {
        logic                 is_query;
        logic                 skip;
        logic [TAP_COUNT-1:0] tap_ok;
    } cmd_flags_t;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

/* src/glgs_stream_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface glgs_in_if #(
    parameter int SAMPLE_BITS = glgs_pkg::DEF_SAMPLE_BITS
);
    import glgs_pkg::*;

    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [COORD_BITS-1:0]         col;
    logic [COORD_BITS-1:0]         row;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, kind, col, row, sample, input ready);
    modport sink (input valid, kind, col, row, sample, output ready);
endinterface

interface glgs_out_if;
    import glgs_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [LAP_BITS-1:0]  laplacian;
    logic signed [GRAD_BITS-1:0] grad_x_twice;
    logic signed [GRAD_BITS-1:0] grad_y_twice;
    logic                        out_of_range;

    modport source (output valid, laplacian, grad_x_twice, grad_y_twice, out_of_range,
                    input ready);
    modport sink (input valid, laplacian, grad_x_twice, grad_y_twice, out_of_range,
                  output ready);
endinterface

/* src/glgs_front.sv */
// Front end: configuration registers, item classification and neighbor address resolution.
module glgs_front #(
    parameter int MAX_WIDTH   = glgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = glgs_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = glgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    glgs_in_if.sink                                in_ch,
    input  logic                                   cfg_we,
    input  logic [glgs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [glgs_pkg::CFG_BITS-1:0]          cfg_data,
    output logic                                   cmd_valid,
    input  logic                                   cmd_ready,
    output glgs_pkg::cmd_flags_t                   cmd_flags,
    output logic [glgs_pkg::TAP_COUNT-1:0]
                 [glgs_pkg::addr_bits(MAX_WIDTH*MAX_HEIGHT)-1:0] cmd_addr,
    output logic signed [SAMPLE_BITS-1:0]          cmd_sample
);
    import glgs_pkg::*;

    localparam int ADDR_BITS = addr_bits(MAX_WIDTH * MAX_HEIGHT);
    localparam int POS_BITS  = CFG_BITS;

    typedef struct packed {
        logic                ok;
        logic [POS_BITS-1:0] pos;
    } axis_t;

    logic [CFG_BITS-1:0]  grid_width_reg;
    logic [CFG_BITS-1:0]  grid_height_reg;
    logic [MODE_BITS-1:0] edge_mode_reg;

    logic [POS_BITS-1:0] ext_w;
    logic [POS_BITS-1:0] ext_h;
    logic [POS_BITS-1:0] x;
    logic [POS_BITS-1:0] y;
    axis_t               x_dn;
    axis_t               x_up;
    axis_t               y_dn;
    axis_t               y_up;
    logic                is_query;
    logic                query_oor;
    logic                write_beyond;

    function automatic logic [POS_BITS-1:0] clamp_extent(input logic [POS_BITS-1:0] v,
                                                         input int maxv);
        if (v == '0) begin
            return POS_BITS'(1);
        end
        if (int'(v) > maxv) begin
            return POS_BITS'(maxv);
        end
        return v;
    endfunction

    function automatic axis_t step_down(input logic [POS_BITS-1:0] p,
                                        input logic [POS_BITS-1:0] ext,
                                        input logic [MODE_BITS-1:0] mode);
        axis_t r;
        r.ok  = 1'b1;
        r.pos = p;
        if (p != '0) begin
            r.pos = p - POS_BITS'(1);
        end
        else begin
            unique case (mode)
                EDGE_PERIODIC: r.pos = ext - POS_BITS'(1);
                EDGE_REFLECT:  r.pos = (ext == POS_BITS'(1)) ? '0 : POS_BITS'(1);
                EDGE_ZERO:     r.ok  = 1'b0;
                EDGE_CLAMP:    r.pos = '0;
            endcase
        end
        return r;
    endfunction

    function automatic axis_t step_up(input logic [POS_BITS-1:0] p,
                                      input logic [POS_BITS-1:0] ext,
                                      input logic [MODE_BITS-1:0] mode);
        axis_t r;
        r.ok  = 1'b1;
        r.pos = p;
        if ((p + POS_BITS'(1)) < ext) begin
            r.pos = p + POS_BITS'(1);
        end
        else begin
            unique case (mode)
                EDGE_PERIODIC: r.pos = '0;
                EDGE_REFLECT:  r.pos = (ext == POS_BITS'(1)) ? '0 : ext - POS_BITS'(2);
                EDGE_ZERO:     r.ok  = 1'b0;
                EDGE_CLAMP:    r.pos = ext - POS_BITS'(1);
            endcase
        end
        return r;
    endfunction

    function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [POS_BITS-1:0] px,
                                                       input logic [POS_BITS-1:0] py);
        int lin;
        lin = int'(py) * MAX_WIDTH + int'(px);
        return ADDR_BITS'(lin);
    endfunction

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            grid_width_reg  <= RESET_GRID_WIDTH;
            grid_height_reg <= RESET_GRID_HEIGHT;
            edge_mode_reg   <= RESET_EDGE_MODE;
        end
        else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                REG_GRID_HEIGHT: grid_height_reg <= cfg_data;
                REG_EDGE_MODE:   edge_mode_reg   <= cfg_data[MODE_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        ext_w        = clamp_extent(grid_width_reg, MAX_WIDTH);
        ext_h        = clamp_extent(grid_height_reg, MAX_HEIGHT);
        x            = POS_BITS'(in_ch.col);
        y            = POS_BITS'(in_ch.row);
        x_dn         = step_down(x, ext_w, edge_mode_reg);
        x_up         = step_up(x, ext_w, edge_mode_reg);
        y_dn         = step_down(y, ext_h, edge_mode_reg);
        y_up         = step_up(y, ext_h, edge_mode_reg);
        is_query     = (in_ch.kind == KIND_QUERY);
        query_oor    = (x >= ext_w) || (y >= ext_h);
        write_beyond = !((int'(in_ch.col) < MAX_WIDTH) && (int'(in_ch.row) < MAX_HEIGHT));

        cmd_flags.is_query      = is_query;
        cmd_flags.skip          = is_query ? query_oor : write_beyond;
        cmd_flags.tap_ok        = '0;
        cmd_flags.tap_ok[TAP_C] = 1'b1;
        cmd_flags.tap_ok[TAP_N] = y_dn.ok;
        cmd_flags.tap_ok[TAP_S] = y_up.ok;
        cmd_flags.tap_ok[TAP_E] = x_up.ok;
        cmd_flags.tap_ok[TAP_W] = x_dn.ok;

        cmd_addr[TAP_C] = cell_addr(x, y);
        cmd_addr[TAP_N] = cell_addr(x, y_dn.pos);
        cmd_addr[TAP_S] = cell_addr(x, y_up.pos);
        cmd_addr[TAP_E] = cell_addr(x_up.pos, y);
        cmd_addr[TAP_W] = cell_addr(x_dn.pos, y);
    end

    assign cmd_valid   = in_ch.valid;
    assign in_ch.ready = cmd_ready;
    assign cmd_sample  = in_ch.sample;

endmodule

/* src/glgs_cmd_queue.sv */
// Two-entry command queue between the front end and the back end.
module glgs_cmd_queue #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int DEPTH    = 2;
    localparam int PTR_BITS = 1;
    localparam int CNT_BITS = 2;

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/glgs_back.sv */
// Back end: grid memory, five-read stencil sequencer and result register.
module glgs_back #(
    parameter int MAX_WIDTH   = glgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = glgs_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = glgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cmd_valid,
    output logic                                   cmd_ready,
    input  glgs_pkg::cmd_flags_t                   cmd_flags,
    input  logic [glgs_pkg::TAP_COUNT-1:0]
                 [glgs_pkg::addr_bits(MAX_WIDTH*MAX_HEIGHT)-1:0] cmd_addr,
    input  logic signed [SAMPLE_BITS-1:0]          cmd_sample,
    glgs_out_if.source                             out_ch
);
    import glgs_pkg::*;

    localparam int ADDR_BITS = addr_bits(MAX_WIDTH * MAX_HEIGHT);
    localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
    localparam int SUM_BITS  = SAMPLE_BITS + 3;
    localparam int WIDE      = (SUM_BITS > LAP_BITS) ? SUM_BITS : LAP_BITS;
    localparam int STEP_BITS = 3;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    localparam logic [STEP_BITS-1:0] STEP_FIRST = STEP_BITS'(1);
    localparam logic [STEP_BITS-1:0] STEP_LAST  = STEP_BITS'(TAP_COUNT);

    logic [SAMPLE_BITS-1:0] grid_mem [DEPTH];
    logic [SAMPLE_BITS-1:0] mem_rdata_reg;

    logic                 state_reg;
    logic                 state_next;
    logic [STEP_BITS-1:0] step_reg;
    logic [STEP_BITS-1:0] step_next;
    logic [ADDR_BITS-1:0] addr_reg [TAP_COUNT];
    logic [TAP_COUNT-1:0] tap_ok_reg;
    logic signed [SAMPLE_BITS-1:0] val_reg [TAP_COUNT];

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic signed [LAP_BITS-1:0]  lap_reg;
    logic signed [GRAD_BITS-1:0] gx_reg;
    logic signed [GRAD_BITS-1:0] gy_reg;
    logic                        oor_reg;

    logic                   out_free;
    logic                   pop;
    logic                   start_query;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_BITS-1:0]   mem_addr;
    logic signed [SAMPLE_BITS-1:0] rd_masked;
    logic                   load_oor;
    logic                   load_result;

    logic signed [WIDE-1:0] xc;
    logic signed [WIDE-1:0] xn;
    logic signed [WIDE-1:0] xs;
    logic signed [WIDE-1:0] xe;
    logic signed [WIDE-1:0] xw;
    logic signed [WIDE-1:0] lap_wide;
    logic signed [WIDE-1:0] gx_wide;
    logic signed [WIDE-1:0] gy_wide;

    assign out_free = !out_valid_reg || out_ch.ready;

    always_comb begin
        state_next  = state_reg;
        step_next   = step_reg;
        cmd_ready   = 1'b0;
        start_query = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_addr    = cmd_addr[TAP_C];
        load_oor    = 1'b0;
        load_result = 1'b0;
        rd_masked   = tap_ok_reg[step_reg - STEP_FIRST] ? mem_rdata_reg : '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    priority if (!cmd_flags.is_query) begin
                        cmd_ready = 1'b1;
                        mem_we    = !cmd_flags.skip;
                    end
                    else if (cmd_flags.skip) begin
                        cmd_ready = out_free;
                        load_oor  = out_free;
                    end
                    else begin
                        cmd_ready   = 1'b1;
                        start_query = 1'b1;
                        mem_re      = 1'b1;
                        state_next  = ST_READ;
                        step_next   = STEP_FIRST;
                    end
                end
            end
            ST_READ: begin
                if (step_reg != STEP_LAST) begin
                    mem_re    = 1'b1;
                    mem_addr  = addr_reg[step_reg];
                    step_next = step_reg + STEP_BITS'(1);
                end
                else if (out_free) begin
                    load_result = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
        endcase
        pop = cmd_valid && cmd_ready;
    end

    always_comb begin
        xc       = WIDE'(val_reg[TAP_C]);
        xn       = WIDE'(val_reg[TAP_N]);
        xs       = WIDE'(val_reg[TAP_S]);
        xe       = WIDE'(val_reg[TAP_E]);
        xw       = WIDE'(rd_masked);
        lap_wide = xn + xs + xe + xw - (xc <<< 2);
        gx_wide  = xe - xw;
        gy_wide  = xs - xn;
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load_oor || load_result) begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (mem_we) begin
            grid_mem[mem_addr] <= cmd_sample;
        end
        if (mem_re) begin
            mem_rdata_reg <= grid_mem[mem_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (start_query && pop) begin
            for (int k = 0; k < TAP_COUNT; k++) begin
                addr_reg[k] <= cmd_addr[k];
            end
            tap_ok_reg <= cmd_flags.tap_ok;
        end
        if (state_reg == ST_READ && step_reg != STEP_LAST) begin
            val_reg[step_reg - STEP_FIRST] <= rd_masked;
        end
        if (load_oor) begin
            lap_reg <= '0;
            gx_reg  <= '0;
            gy_reg  <= '0;
            oor_reg <= 1'b1;
        end
        else if (load_result) begin
            lap_reg <= lap_wide[LAP_BITS-1:0];
            gx_reg  <= gx_wide[GRAD_BITS-1:0];
            gy_reg  <= gy_wide[GRAD_BITS-1:0];
            oor_reg <= 1'b0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.laplacian    = lap_reg;
    assign out_ch.grad_x_twice = gx_reg;
    assign out_ch.grad_y_twice = gy_reg;
    assign out_ch.out_of_range = oor_reg;

endmodule

/* src/grid_laplacian_gradient_stencil_core.sv */
// Top level of the five-point Laplacian and central-difference gradient core.
// The core keeps a grid of signed Q8.8 samples in a single-ported memory. A write
// transaction stores one cell and does not wait on the output channel. A query
// transaction reads the center cell and its four neighbors one after another
// through that single memory port and then combines them, so it occupies the back
// end for five memory reads and a final step that forms and registers the result
// once the output is free, all that an out-of-range query waits for. The front end
// resolves neighbor addresses from the edge mode and accepts a new transaction
// whenever the two-entry command queue has room, also while a result waits on the
// output channel. Configuration writes take effect on the next transaction.
module grid_laplacian_gradient_stencil_core #(
    parameter int MAX_WIDTH   = glgs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = glgs_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = glgs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    glgs_in_if.sink                             in_ch,
    glgs_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [glgs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [glgs_pkg::CFG_BITS-1:0]       cfg_data
);
    import glgs_pkg::*;

    localparam int ADDR_BITS = addr_bits(MAX_WIDTH * MAX_HEIGHT);
    localparam int CMD_BITS  = $bits(cmd_flags_t) + TAP_COUNT * ADDR_BITS + SAMPLE_BITS;

    logic                                  f_valid;
    logic                                  f_ready;
    cmd_flags_t                            f_flags;
    logic [TAP_COUNT-1:0][ADDR_BITS-1:0]   f_addr;
    logic signed [SAMPLE_BITS-1:0]         f_sample;

    logic                                  q_valid;
    logic                                  q_ready;
    cmd_flags_t                            q_flags;
    logic [TAP_COUNT-1:0][ADDR_BITS-1:0]   q_addr;
    logic signed [SAMPLE_BITS-1:0]         q_sample;

    logic [CMD_BITS-1:0]                   push_data;
    logic [CMD_BITS-1:0]                   pop_data;

    glgs_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (f_valid),
        .cmd_ready  (f_ready),
        .cmd_flags  (f_flags),
        .cmd_addr   (f_addr),
        .cmd_sample (f_sample)
    );

    assign push_data = {f_flags, f_addr, f_sample};

    glgs_cmd_queue #(
        .WIDTH (CMD_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (push_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (pop_data)
    );

    assign {q_flags, q_addr, q_sample} = pop_data;

    glgs_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd_flags  (q_flags),
        .cmd_addr   (q_addr),
        .cmd_sample (q_sample),
        .out_ch     (out_ch)
    );

endmodule

/* src/glgs_checker.sv */
// Port-level checker of the stencil core and its bind to the top level.
`include "grid_laplacian_gradient_stencil_core_assert.svh"

module glgs_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [glgs_pkg::LAP_BITS-1:0]  laplacian,
    input logic signed [glgs_pkg::GRAD_BITS-1:0] grad_x_twice,
    input logic signed [glgs_pkg::GRAD_BITS-1:0] grad_y_twice,
    input logic                                  out_of_range
);
    import glgs_pkg::*;

    `GLGS_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    `GLGS_ASSERT_NEXT(a_out_payload_hold, clk, rst_n, out_valid && !out_ready, $stable(laplacian) && $stable(grad_x_twice) && $stable(grad_y_twice) && $stable(out_of_range))

    `GLGS_ASSERT_SAME(a_oor_zero_fields, clk, rst_n, out_valid && out_of_range, laplacian == '0 && grad_x_twice == '0 && grad_y_twice == '0)

    // The Laplacian and the sum of both doubled gradients always share parity.
    `GLGS_ASSERT_SAME(a_result_parity, clk, rst_n, out_valid, laplacian[0] == (grad_x_twice[0] ^ grad_y_twice[0]))

endmodule

bind grid_laplacian_gradient_stencil_core glgs_checker u_glgs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .laplacian    (out_ch.laplacian),
    .grad_x_twice (out_ch.grad_x_twice),
    .grad_y_twice (out_ch.grad_y_twice),
    .out_of_range (out_ch.out_of_range)
);
